// ----- rtl/sch_pkg.sv -----
// Package for the swept circle segment hit test.
// Holds widths, ratio codes and the word layouts shared by the pipeline modules.
// No dependencies.
package sch_pkg;

    localparam int VW    = 24;
    localparam int NFLD  = 12;
    localparam int RW    = 27;
    localparam int DW    = 26;
    localparam int PRW   = 54;
    localparam int DOTW  = 55;
    localparam int WIDEW = 111;
    localparam int QW    = 17;
    localparam int QFRAC = 16;
    localparam int PW    = 30;
    localparam int QSW   = 58;
    localparam int HALF  = 32768;
    localparam int RADW  = 16;

    localparam logic [QW-1:0]   ONE_Q        = 17'h10000;
    localparam logic [RADW-1:0] RADIUS_RESET = 16'd7168;

    typedef enum logic [1:0] {
        RATIO_ZERO,
        RATIO_ONE,
        RATIO_DIV
    } t_ratio;

    typedef struct packed {
        logic signed [RW-1:0] rx;
        logic signed [RW-1:0] ry;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic signed [VW-1:0] cpx;
        logic signed [VW-1:0] cpy;
        logic signed [VW-1:0] apx;
        logic signed [VW-1:0] apy;
    } t_base;

    typedef struct packed {
        logic signed [DOTW-1:0] a;
        logic signed [DOTW-1:0] b;
        logic signed [DOTW-1:0] c;
        logic signed [DOTW-1:0] d1;
        logic signed [DOTW-1:0] e;
        t_base                  base;
    } t_dots;

    typedef struct packed {
        logic signed [DOTW-1:0] c;
        t_base                  base;
    } t_geoc;

    typedef struct packed {
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic signed [VW-1:0] apx;
        logic signed [VW-1:0] apy;
    } t_spay;

endpackage

// ----- rtl/swept_circle_segment_hit_test.sv -----
// Swept circle versus moving segment hit test, fully pipelined.
// Throughput is one word per cycle while the output is not stalled; every stage has its own valid and ready.
// The two 17-stage ratio pipelines set the depth; each stage after the mode stage yields one quotient bit.
// Synchronous active-low reset clears all valid bits and sets radius to 7168.
// Depends on sch_pkg, sch_reg, sch_dots, sch_wmul and sch_div.
module swept_circle_segment_hit_test import sch_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [RADW-1:0]    i_cfg_wdata,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // circle_prev_x, circle_prev_y, circle_cur_x, circle_cur_y, end_a_prev_x,
    // end_a_prev_y, end_a_cur_x, end_a_cur_y, end_b_prev_x, end_b_prev_y,
    // end_b_cur_x, end_b_cur_y; 24 bits each from the lowest bit up.
    input  logic [NFLD*VW-1:0] s_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // hit in bit 0, zeros above.
    output logic [7:0]         m_axis_tdata
);

    localparam int PMW = RW + QW + 1;
    localparam int PQW = PW + DW;
    localparam int RMW = DW + QW + 1;
    localparam int SQW = 2 * PW;
    localparam int R2W = 2 * RADW + 2;

    typedef struct packed {
        logic signed [PMW-1:0] mrx;
        logic signed [PMW-1:0] mry;
        t_geoc                 g;
    } t_p1;

    typedef struct packed {
        logic signed [PW-1:0]   px, py, qvx, qvy;
        logic signed [DOTW-1:0] c;
        logic signed [DW-1:0]   dx, dy;
        logic signed [VW-1:0]   apx, apy;
    } t_p2;

    typedef struct packed {
        logic signed [PQW-1:0]  pqx, pqy;
        logic signed [PW-1:0]   px, py;
        logic signed [DOTW-1:0] c;
        logic signed [DW-1:0]   dx, dy;
        logic signed [VW-1:0]   apx, apy;
    } t_p3;

    typedef struct packed {
        logic signed [QSW-1:0]  q;
        logic signed [DOTW-1:0] c;
        t_spay                  sp;
    } t_p4;

    typedef struct packed {
        logic signed [RMW-1:0] mdx, mdy;
        t_spay                 sp;
    } t_r1;

    typedef struct packed {
        logic signed [PW-1:0] ex, ey;
    } t_r2;

    typedef struct packed {
        logic [SQW-1:0] sqx, sqy;
    } t_r3;

    logic [RADW-1:0] r_radius;
    logic [R2W-1:0]  r_r2sq;

    t_dots                   w_dots;
    logic signed [WIDEW-1:0] w_num, w_den;
    t_geoc                   w_wpay, w_gt;
    logic [$bits(t_geoc)-1:0] w_gt_vec;
    logic [QW-1:0]           w_t, w_s;
    logic [$bits(t_spay)-1:0] w_sp_vec;
    t_spay                   w_sp;

    t_p1 n_p1, w_p1;
    t_p2 n_p2, w_p2;
    t_p3 n_p3, w_p3;
    t_p4 n_p4, w_p4;
    t_r1 n_r1, w_r1;
    t_r2 n_r2, w_r2;
    t_r3 n_r3, w_r3;
    logic n_hit, w_hit;

    logic v_dots, rdy_wmul, v_wmul, rdy_dt, v_dt;
    logic rdy_p1, v_p1, rdy_p2, v_p2, rdy_p3, v_p3, rdy_p4, v_p4;
    logic rdy_ds, v_ds, rdy_r1, v_r1, rdy_r2, v_r2, rdy_r3, v_r3, rdy_r4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r2sq <= {32'(r_radius) * 32'(r_radius), 2'b00};
    end

    sch_dots u_dots (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_data(s_axis_tdata),
        .o_valid(v_dots), .i_ready(rdy_wmul), .o_data(w_dots)
    );

    sch_wmul u_wmul (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(v_dots), .o_ready(rdy_wmul), .i_data(w_dots),
        .o_valid(v_wmul), .i_ready(rdy_dt),
        .o_num(w_num), .o_den(w_den), .o_pay(w_wpay)
    );

    sch_div #(.W(WIDEW), .PW($bits(t_geoc))) u_div_t (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(v_wmul), .o_ready(rdy_dt),
        .i_num(w_num), .i_den(w_den), .i_pay(w_wpay),
        .o_valid(v_dt), .i_ready(rdy_p1), .o_q(w_t), .o_pay(w_gt_vec)
    );

    assign w_gt = t_geoc'(w_gt_vec);

    always_comb begin
        n_p1.mrx = PMW'(w_gt.base.rx) * PMW'($signed({1'b0, w_t}));
        n_p1.mry = PMW'(w_gt.base.ry) * PMW'($signed({1'b0, w_t}));
        n_p1.g   = w_gt;
    end

    always_comb begin
        logic signed [PMW-1:0] shx, shy;
        shx      = (w_p1.mrx + PMW'(HALF)) >>> QFRAC;
        shy      = (w_p1.mry + PMW'(HALF)) >>> QFRAC;
        n_p2.px  = (PW'(w_p1.g.base.cpx) <<< 1) + PW'(shx);
        n_p2.py  = (PW'(w_p1.g.base.cpy) <<< 1) + PW'(shy);
        n_p2.qvx = n_p2.px - (PW'(w_p1.g.base.apx) <<< 1);
        n_p2.qvy = n_p2.py - (PW'(w_p1.g.base.apy) <<< 1);
        n_p2.c   = w_p1.g.c;
        n_p2.dx  = w_p1.g.base.dx;
        n_p2.dy  = w_p1.g.base.dy;
        n_p2.apx = w_p1.g.base.apx;
        n_p2.apy = w_p1.g.base.apy;
    end

    always_comb begin
        n_p3.pqx = PQW'(w_p2.qvx) * PQW'(w_p2.dx);
        n_p3.pqy = PQW'(w_p2.qvy) * PQW'(w_p2.dy);
        n_p3.px  = w_p2.px;
        n_p3.py  = w_p2.py;
        n_p3.c   = w_p2.c;
        n_p3.dx  = w_p2.dx;
        n_p3.dy  = w_p2.dy;
        n_p3.apx = w_p2.apx;
        n_p3.apy = w_p2.apy;
    end

    always_comb begin
        n_p4.q      = QSW'(w_p3.pqx) + QSW'(w_p3.pqy);
        n_p4.c      = w_p3.c;
        n_p4.sp.px  = w_p3.px;
        n_p4.sp.py  = w_p3.py;
        n_p4.sp.dx  = w_p3.dx;
        n_p4.sp.dy  = w_p3.dy;
        n_p4.sp.apx = w_p3.apx;
        n_p4.sp.apy = w_p3.apy;
    end

    sch_div #(.W(QSW), .PW($bits(t_spay))) u_div_s (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(v_p4), .o_ready(rdy_ds),
        .i_num(w_p4.q), .i_den(QSW'(w_p4.c)), .i_pay(w_p4.sp),
        .o_valid(v_ds), .i_ready(rdy_r1), .o_q(w_s), .o_pay(w_sp_vec)
    );

    assign w_sp = t_spay'(w_sp_vec);

    always_comb begin
        n_r1.mdx = RMW'(w_sp.dx) * RMW'($signed({1'b0, w_s}));
        n_r1.mdy = RMW'(w_sp.dy) * RMW'($signed({1'b0, w_s}));
        n_r1.sp  = w_sp;
    end

    always_comb begin
        logic signed [RMW-1:0] shx, shy;
        logic signed [PW-1:0]  qx, qy;
        shx     = (w_r1.mdx + RMW'(HALF)) >>> QFRAC;
        shy     = (w_r1.mdy + RMW'(HALF)) >>> QFRAC;
        qx      = (PW'(w_r1.sp.apx) <<< 1) + PW'(shx);
        qy      = (PW'(w_r1.sp.apy) <<< 1) + PW'(shy);
        n_r2.ex = w_r1.sp.px - qx;
        n_r2.ey = w_r1.sp.py - qy;
    end

    always_comb begin
        n_r3.sqx = SQW'(w_r2.ex) * SQW'(w_r2.ex);
        n_r3.sqy = SQW'(w_r2.ey) * SQW'(w_r2.ey);
    end

    assign n_hit = ({1'b0, w_r3.sqx} + {1'b0, w_r3.sqy}) <= (SQW+1)'(r_r2sq);

    sch_reg #(.W($bits(t_p1))) u_p1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(v_dt), .o_ready(rdy_p1), .i_data(n_p1),
        .o_valid(v_p1), .i_ready(rdy_p2), .o_data(w_p1)
    );

    sch_reg #(.W($bits(t_p2))) u_p2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(v_p1), .o_ready(rdy_p2), .i_data(n_p2),
        .o_valid(v_p2), .i_ready(rdy_p3), .o_data(w_p2)
    );

    sch_reg #(.W($bits(t_p3))) u_p3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(v_p2), .o_ready(rdy_p3), .i_data(n_p3),
        .o_valid(v_p3), .i_ready(rdy_p4), .o_data(w_p3)
    );

    sch_reg #(.W($bits(t_p4))) u_p4 (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(v_p3), .o_ready(rdy_p4), .i_data(n_p4),
        .o_valid(v_p4), .i_ready(rdy_ds), .o_data(w_p4)
    );

    sch_reg #(.W($bits(t_r1))) u_r1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(v_ds), .o_ready(rdy_r1), .i_data(n_r1),
        .o_valid(v_r1), .i_ready(rdy_r2), .o_data(w_r1)
    );

    sch_reg #(.W($bits(t_r2))) u_r2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(v_r1), .o_ready(rdy_r2), .i_data(n_r2),
        .o_valid(v_r2), .i_ready(rdy_r3), .o_data(w_r2)
    );

    sch_reg #(.W($bits(t_r3))) u_r3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(v_r2), .o_ready(rdy_r3), .i_data(n_r3),
        .o_valid(v_r3), .i_ready(rdy_r4), .o_data(w_r3)
    );

    sch_reg #(.W(1)) u_r4 (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(v_r3), .o_ready(rdy_r4), .i_data(n_hit),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(w_hit)
    );

    assign m_axis_tdata = {7'b0000000, w_hit};

endmodule

// ----- rtl/sch_reg.sv -----
// Pipeline register with valid and ready that lets bubbles collapse.
// Generic data width; no package dependencies.
module sch_reg #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);

    logic         r_valid;
    logic [W-1:0] r_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

// ----- rtl/sch_dots.sv -----
// Front stages: relative motion vectors, their products and the five dot products.
// Depends on sch_pkg and sch_reg.
module sch_dots import sch_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [NFLD*VW-1:0] i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output t_dots              o_data
);

    typedef struct packed {
        logic signed [DW-1:0] mx;
        logic signed [DW-1:0] my;
        t_base                base;
    } t_vec;

    typedef struct packed {
        logic signed [PRW-1:0] rrx, rry, rdx, rdy, ddx, ddy, rmx, rmy, dmx, dmy;
        t_base                 base;
    } t_prod;

    logic signed [VW-1:0] f [NFLD];
    t_vec  n_vec, w_vec;
    t_prod n_prod, w_prod;
    t_dots n_dots;
    logic  v_vec, v_prod, rdy_prod, rdy_dots;

    always_comb begin
        for (int k = 0; k < NFLD; k++) begin
            f[k] = i_data[k*VW +: VW];
        end
        n_vec.base.rx  = ((RW'(f[2]) - RW'(f[0])) <<< 1)
                       - ((RW'(f[6]) - RW'(f[4])) + (RW'(f[10]) - RW'(f[8])));
        n_vec.base.ry  = ((RW'(f[3]) - RW'(f[1])) <<< 1)
                       - ((RW'(f[7]) - RW'(f[5])) + (RW'(f[11]) - RW'(f[9])));
        n_vec.base.dx  = (DW'(f[8]) - DW'(f[4])) <<< 1;
        n_vec.base.dy  = (DW'(f[9]) - DW'(f[5])) <<< 1;
        n_vec.mx       = (DW'(f[0]) - DW'(f[4])) <<< 1;
        n_vec.my       = (DW'(f[1]) - DW'(f[5])) <<< 1;
        n_vec.base.cpx = f[0];
        n_vec.base.cpy = f[1];
        n_vec.base.apx = f[4];
        n_vec.base.apy = f[5];
    end

    always_comb begin
        n_prod.rrx  = PRW'(w_vec.base.rx) * PRW'(w_vec.base.rx);
        n_prod.rry  = PRW'(w_vec.base.ry) * PRW'(w_vec.base.ry);
        n_prod.rdx  = PRW'(w_vec.base.rx) * PRW'(w_vec.base.dx);
        n_prod.rdy  = PRW'(w_vec.base.ry) * PRW'(w_vec.base.dy);
        n_prod.ddx  = PRW'(w_vec.base.dx) * PRW'(w_vec.base.dx);
        n_prod.ddy  = PRW'(w_vec.base.dy) * PRW'(w_vec.base.dy);
        n_prod.rmx  = PRW'(w_vec.base.rx) * PRW'(w_vec.mx);
        n_prod.rmy  = PRW'(w_vec.base.ry) * PRW'(w_vec.my);
        n_prod.dmx  = PRW'(w_vec.base.dx) * PRW'(w_vec.mx);
        n_prod.dmy  = PRW'(w_vec.base.dy) * PRW'(w_vec.my);
        n_prod.base = w_vec.base;
    end

    always_comb begin
        n_dots.a    = DOTW'(w_prod.rrx) + DOTW'(w_prod.rry);
        n_dots.b    = DOTW'(w_prod.rdx) + DOTW'(w_prod.rdy);
        n_dots.c    = DOTW'(w_prod.ddx) + DOTW'(w_prod.ddy);
        n_dots.d1   = DOTW'(w_prod.rmx) + DOTW'(w_prod.rmy);
        n_dots.e    = DOTW'(w_prod.dmx) + DOTW'(w_prod.dmy);
        n_dots.base = w_prod.base;
    end

    sch_reg #(.W($bits(t_vec))) u_vec (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(n_vec),
        .o_valid(v_vec), .i_ready(rdy_prod), .o_data(w_vec)
    );

    sch_reg #(.W($bits(t_prod))) u_prod (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(v_vec), .o_ready(rdy_prod), .i_data(n_prod),
        .o_valid(v_prod), .i_ready(rdy_dots), .o_data(w_prod)
    );

    sch_reg #(.W($bits(t_dots))) u_dots (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(v_prod), .o_ready(rdy_dots), .i_data(n_dots),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

endmodule

// ----- rtl/sch_wmul.sv -----
// Wide products b*e, c*d1, a*c, b*b split into partial products over stages,
// then the numerator and denominator of the closest-approach time.
// Depends on sch_pkg and sch_reg.
module sch_wmul import sch_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_dots                   i_data,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [WIDEW-1:0] o_num,
    output logic signed [WIDEW-1:0] o_den,
    output t_geoc                   o_pay
);

    localparam int LW  = 27;
    localparam int HW  = DOTW - LW;
    localparam int HPW = 2 * HW;
    localparam int LPW = 2 * LW;
    localparam int MW  = HPW + 1;

    typedef struct packed {
        logic [3:0][HPW-1:0] hh;
        logic [3:0][HPW-1:0] hl;
        logic [3:0][HPW-1:0] lh;
        logic [3:0][LPW-1:0] ll;
        t_geoc               pay;
    } t_pp;

    typedef struct packed {
        logic [3:0][HPW-1:0] hh;
        logic [3:0][MW-1:0]  mid;
        logic [3:0][LPW-1:0] ll;
        t_geoc               pay;
    } t_mid;

    typedef struct packed {
        logic [3:0][WIDEW-1:0] full;
        t_geoc                 pay;
    } t_full;

    typedef struct packed {
        logic signed [WIDEW-1:0] num;
        logic signed [WIDEW-1:0] den;
        t_geoc                   pay;
    } t_diff;

    logic signed [DOTW-1:0] x [4];
    logic signed [DOTW-1:0] y [4];
    t_pp   n_pp, w_pp;
    t_mid  n_mid, w_mid;
    t_full n_full, w_full;
    t_diff n_diff, w_diff;
    logic  v_pp, v_mid, v_full, rdy_mid, rdy_full, rdy_diff;

    always_comb begin
        logic signed [HW-1:0] xh, yh, xls, yls;
        x[0] = i_data.b;  y[0] = i_data.e;
        x[1] = i_data.c;  y[1] = i_data.d1;
        x[2] = i_data.a;  y[2] = i_data.c;
        x[3] = i_data.b;  y[3] = i_data.b;
        for (int k = 0; k < 4; k++) begin
            xh  = $signed(x[k][DOTW-1:LW]);
            yh  = $signed(y[k][DOTW-1:LW]);
            xls = $signed({1'b0, x[k][LW-1:0]});
            yls = $signed({1'b0, y[k][LW-1:0]});
            n_pp.hh[k] = HPW'(xh) * HPW'(yh);
            n_pp.hl[k] = HPW'(xh) * HPW'(yls);
            n_pp.lh[k] = HPW'(xls) * HPW'(yh);
            n_pp.ll[k] = LPW'(x[k][LW-1:0]) * LPW'(y[k][LW-1:0]);
        end
        n_pp.pay.c    = i_data.c;
        n_pp.pay.base = i_data.base;
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_mid.hh[k]  = w_pp.hh[k];
            n_mid.ll[k]  = w_pp.ll[k];
            n_mid.mid[k] = MW'($signed(w_pp.hl[k])) + MW'($signed(w_pp.lh[k]));
        end
        n_mid.pay = w_pp.pay;
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_full.full[k] = WIDEW'($signed({w_mid.hh[k], w_mid.ll[k]}))
                           + (WIDEW'($signed(w_mid.mid[k])) <<< LW);
        end
        n_full.pay = w_mid.pay;
    end

    always_comb begin
        n_diff.num = $signed(w_full.full[0]) - $signed(w_full.full[1]);
        n_diff.den = $signed(w_full.full[2]) - $signed(w_full.full[3]);
        n_diff.pay = w_full.pay;
    end

    sch_reg #(.W($bits(t_pp))) u_pp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(n_pp),
        .o_valid(v_pp), .i_ready(rdy_mid), .o_data(w_pp)
    );

    sch_reg #(.W($bits(t_mid))) u_mid (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(v_pp), .o_ready(rdy_mid), .i_data(n_mid),
        .o_valid(v_mid), .i_ready(rdy_full), .o_data(w_mid)
    );

    sch_reg #(.W($bits(t_full))) u_full (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(v_mid), .o_ready(rdy_full), .i_data(n_full),
        .o_valid(v_full), .i_ready(rdy_diff), .o_data(w_full)
    );

    sch_reg #(.W($bits(t_diff))) u_diff (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(v_full), .o_ready(rdy_diff), .i_data(n_diff),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(w_diff)
    );

    assign o_num = w_diff.num;
    assign o_den = w_diff.den;
    assign o_pay = w_diff.pay;

endmodule

// ----- rtl/sch_div.sv -----
// Pipelined clamped ratio num/den in 0..1 with 16 fraction bits, one quotient bit a stage after the mode stage.
// Depends on sch_pkg and sch_reg.
module sch_div import sch_pkg::*; #(
    parameter int W  = 58,
    parameter int PW = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [W-1:0] i_num,
    input  logic signed [W-1:0] i_den,
    input  logic [PW-1:0]       i_pay,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [QW-1:0]       o_q,
    output logic [PW-1:0]       o_pay
);

    typedef struct packed {
        t_ratio           mode;
        logic [W-1:0]     rem;
        logic [W-1:0]     den;
        logic [QFRAC-1:0] q;
        logic [PW-1:0]    pay;
    } t_dstage;

    t_dstage n_st [QFRAC+1];
    t_dstage st   [QFRAC+1];
    logic    vin  [QFRAC+1];
    logic    vout [QFRAC+1];
    logic    rdy  [QFRAC+2];

    always_comb begin
        logic [W-1:0] rem2;
        if (i_den == '0 || i_num[W-1] || i_num == '0) begin
            n_st[0].mode = RATIO_ZERO;
        end else if (i_num >= i_den) begin
            n_st[0].mode = RATIO_ONE;
        end else begin
            n_st[0].mode = RATIO_DIV;
        end
        n_st[0].rem = i_num;
        n_st[0].den = i_den;
        n_st[0].q   = '0;
        n_st[0].pay = i_pay;
        for (int k = 0; k < QFRAC; k++) begin
            rem2        = {st[k].rem[W-2:0], 1'b0};
            n_st[k+1]   = st[k];
            if (rem2 >= st[k].den) begin
                n_st[k+1].rem = rem2 - st[k].den;
                n_st[k+1].q   = {st[k].q[QFRAC-2:0], 1'b1};
            end else begin
                n_st[k+1].rem = rem2;
                n_st[k+1].q   = {st[k].q[QFRAC-2:0], 1'b0};
            end
        end
    end

    assign vin[0]        = i_valid;
    assign o_ready       = rdy[0];
    assign rdy[QFRAC+1]  = i_ready;
    assign o_valid       = vout[QFRAC];
    assign o_pay         = st[QFRAC].pay;

    for (genvar k = 0; k <= QFRAC; k++) begin : g_stage
        if (k > 0) begin : g_link
            assign vin[k] = vout[k-1];
        end
        sch_reg #(.W($bits(t_dstage))) u_st (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_valid(vin[k]), .o_ready(rdy[k]), .i_data(n_st[k]),
            .o_valid(vout[k]), .i_ready(rdy[k+1]), .o_data(st[k])
        );
    end

    always_comb begin
        case (st[QFRAC].mode)
            RATIO_ONE: o_q = ONE_Q;
            RATIO_DIV: o_q = {1'b0, st[QFRAC].q};
            default:   o_q = '0;
        endcase
    end

endmodule

// ----- sim/tb_swept_circle_segment_hit_test.sv -----
// Testbench for the swept circle segment hit test, with its own bit-true predictor.
// Drives directed and random words with random idling and stalls, then checks every result.
// Depends on sch_pkg and the swept_circle_segment_hit_test RTL.
module tb_swept_circle_segment_hit_test import sch_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIR_ROWS   = 14;
    localparam int RAND_ITEMS = 940;
    localparam int DRAIN      = 60;
    localparam int LIMIT      = 400000;
    localparam int FROM_MODEL = -1;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [RADW-1:0]    i_cfg_wdata;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [NFLD*VW-1:0] s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [7:0]         m_axis_tdata;

    logic [RADW-1:0] radius_now;
    bit              hit_queue[$];
    int              errors;
    int              hits_seen;
    int              results_seen;
    int              cycles;
    bit              stall_req;
    bit              quiet;
    int              stall_left;

    // Circle prev, circle cur, A prev, A cur, B prev, B cur; x then y.
    longint dir_tab[DIR_ROWS][NFLD] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
          8388607, 8388607, 8388607, 8388607, 8388607, 8388607},
        '{-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
          -8388608, -8388608, -8388608, -8388608, -8388608, -8388608},
        '{8388607, 8388607, 8388607, 8388607, -8388608, -8388608,
          -8388608, -8388608, -8388608, -8388608, -8388608, -8388608},
        '{-8388608, -8388608, -8388608, -8388608, 8388607, 8388607,
          8388607, 8388607, 8388607, 8388607, 8388607, 8388607},
        '{-2560, 0, 2560, 0, 0, -2560, 0, -2560, 0, 2560, 0, 2560},
        '{-9000, 10000, 9000, 10000, -5000, 0, -5000, 0, 5000, 0, 5000, 0},
        '{-9000, 100, 9000, 100, 300, -4000, 300, 4000, 300, -4000, 300, 4000},
        '{0, 9000, 4000, 9000, -5000, 0, -1000, 0, 5000, 0, 9000, 0},
        '{0, 7168, 0, 7168, -5000, 0, -5000, 0, 5000, 0, 5000, 0},
        '{0, 7169, 0, 7169, -5000, 0, -5000, 0, 5000, 0, 5000, 0},
        '{20000, 0, 20000, 0, -5000, 0, -5000, 0, 5000, 0, 5000, 0},
        '{-30000, 0, -20000, 0, 0, -5000, 0, -5000, 0, 5000, 0, 5000},
        '{8388607, -8388608, -8388608, 8388607, 0, 0, 100, -100, 0, 0, -100, 100}
    };
    int dir_exp[DIR_ROWS] = '{1, 1, 1, 0, 0, FROM_MODEL, FROM_MODEL, FROM_MODEL,
        FROM_MODEL, FROM_MODEL, FROM_MODEL, FROM_MODEL, FROM_MODEL, FROM_MODEL};

    swept_circle_segment_hit_test u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint floor_q16(input longint x);
        return (x + HALF) >>> 16;
    endfunction

    function automatic bit predict_hit(input logic [NFLD*VW-1:0] w, input logic [RADW-1:0] rad);
        longint f[NFLD];
        longint rx, ry, dx, dy, mx, my, a, b, c, d1, e, t, s, px, py, q, qx, qy, ex, ey;
        logic signed [127:0] num, den, wq;
        logic [63:0] dist_sq, r2;
        for (int i = 0; i < NFLD; i++) begin
            f[i] = longint'($signed(w[i*VW +: VW]));
        end
        rx = 2 * (f[2] - f[0]) - ((f[6] - f[4]) + (f[10] - f[8]));
        ry = 2 * (f[3] - f[1]) - ((f[7] - f[5]) + (f[11] - f[9]));
        dx = 2 * (f[8] - f[4]);
        dy = 2 * (f[9] - f[5]);
        mx = 2 * (f[0] - f[4]);
        my = 2 * (f[1] - f[5]);
        a  = rx * rx + ry * ry;
        b  = rx * dx + ry * dy;
        c  = dx * dx + dy * dy;
        d1 = rx * mx + ry * my;
        e  = dx * mx + dy * my;
        num = 128'(b) * 128'(e) - 128'(c) * 128'(d1);
        den = 128'(a) * 128'(c) - 128'(b) * 128'(b);
        if (den == 0 || num <= 0) t = 0;
        else if (num >= den) t = 65536;
        else t = longint'((num <<< 16) / den);
        px = 2 * f[0] + floor_q16(rx * t);
        py = 2 * f[1] + floor_q16(ry * t);
        q  = (px - 2 * f[4]) * dx + (py - 2 * f[5]) * dy;
        wq = 128'(q);
        if (c <= 0 || q <= 0) s = 0;
        else if (q >= c) s = 65536;
        else s = longint'((wq <<< 16) / 128'(c));
        qx = 2 * f[4] + floor_q16(dx * s);
        qy = 2 * f[5] + floor_q16(dy * s);
        ex = px - qx;
        ey = py - qy;
        dist_sq = 64'(ex * ex) + 64'(ey * ey);
        r2 = 64'(rad) * 2;
        return dist_sq <= r2 * r2;
    endfunction

    function automatic logic [NFLD*VW-1:0] pack_word(input longint f[NFLD]);
        logic [NFLD*VW-1:0] w;
        for (int i = 0; i < NFLD; i++) begin
            w[i*VW +: VW] = f[i][VW-1:0];
        end
        return w;
    endfunction

    function automatic logic [NFLD*VW-1:0] random_word();
        longint f[NFLD];
        longint span, bx, by;
        int kind;
        kind = $urandom_range(0, 9);
        span = (kind < 6) ? 4096 : ((kind < 8) ? 65536 : 0);
        bx = $signed(24'($urandom));
        by = $signed(24'($urandom));
        if (kind < 6) begin
            bx = bx >>> 4;
            by = by >>> 4;
        end
        for (int i = 0; i < NFLD; i++) begin
            if (span == 0) f[i] = $signed(24'($urandom));
            else f[i] = ((i % 2) ? by : bx) + longint'($urandom_range(0, 2 * span)) - span;
        end
        // Some segments collapse to a point, some sweeps are parallel to the segment.
        if (kind == 0) begin
            f[8] = f[4];
            f[9] = f[5];
        end
        if (kind == 1) begin
            f[3] = f[1];
            f[5] = f[1] + 300;
            f[9] = f[5];
            f[7] = f[5];
            f[11] = f[5];
        end
        return pack_word(f);
    endfunction

    task automatic send_word(input logic [NFLD*VW-1:0] w);
        s_axis_tdata  <= w;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (!quiet && $urandom_range(0, 99) < 29) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic settle_and_write(input logic [RADW-1:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (hit_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        radius_now  = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (stall_req && stall_left == 0) begin
            stall_left <= 300;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end else begin
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= 29);
        end
    end

    always @(posedge i_clk) begin
        bit expected;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            hit_queue.push_back(predict_hit(s_axis_tdata, radius_now));
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            hits_seen += m_axis_tdata[0];
            if (hit_queue.size() == 0) begin
                $display("%0t: result hit=%0d with no expectation waiting", $time, m_axis_tdata[0]);
                errors++;
            end else begin
                expected = hit_queue.pop_front();
                if (m_axis_tdata !== {7'd0, expected}) begin
                    $display("%0t: hit mismatch, expected %0d, actual %0d (word %h)",
                             $time, expected, m_axis_tdata[0], m_axis_tdata);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("swept_circle_segment_hit_test verification failed");
            $finish;
        end
    end

    initial begin
        logic [RADW-1:0] radius_plan[5] = '{16'd0, 16'hFFFF, 16'd1, 16'd7168, 16'd20000};
        longint row[NFLD];
        bit dir_want;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        radius_now = RADIUS_RESET;
        errors = 0;
        hits_seen = 0;
        results_seen = 0;
        cycles = 0;
        stall_req = 1'b0;
        quiet = 1'b0;
        stall_left = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            row = dir_tab[r];
            dir_want = predict_hit(pack_word(row), radius_now);
            if (dir_exp[r] != FROM_MODEL && dir_exp[r] != int'(dir_want)) begin
                $display("%0t: directed row %0d predictor gives %0d, table says %0d",
                         $time, r, dir_want, dir_exp[r]);
                errors++;
            end
            send_word(pack_word(row));
        end

        for (int p = 0; p < 5; p++) begin
            settle_and_write(p == 4 ? 16'($urandom) : radius_plan[p]);
            for (int i = 0; i < RAND_ITEMS / 5; i++) begin
                quiet = (p == 2);
                if (p == 1 && i == 20) stall_req = 1'b1;
                if (p == 1 && i == 21) stall_req = 1'b0;
                send_word(random_word());
            end
            quiet = 1'b0;
        end

        s_axis_tvalid <= 1'b0;
        while (hit_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        $display("Checked %0d results (%0d hits) over five radius settings,",
                 results_seen, hits_seen);
        $display("including 0 and 65535, with a long output stall and a quiet stretch.");
        if (errors == 0) begin
            $display("swept_circle_segment_hit_test verification clean");
        end else begin
            $display("swept_circle_segment_hit_test verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/sch_pkg.sv
rtl/sch_reg.sv
rtl/sch_dots.sv
rtl/sch_wmul.sv
rtl/sch_div.sv
rtl/swept_circle_segment_hit_test.sv
sim/tb_swept_circle_segment_hit_test.sv
